### rtl/perspective_point_projector_macros.svh
// Assertion helpers shared by ppp_queue and ppp_back.
`ifndef PERSPECTIVE_POINT_PROJECTOR_MACROS_SVH
`define PERSPECTIVE_POINT_PROJECTOR_MACROS_SVH
`ifndef SYNTHESIS
`define PPP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PPP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define PPP_ASSERT(lbl, clk, rst_n, prop, msg)
`define PPP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

### rtl/ppp_pkg.sv
package ppp_pkg;

    localparam int EYE_W     = 31;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_X     = 2'd0,
        CFG_ROW_Y     = 2'd1,
        CFG_ROW_DEPTH = 2'd2,
        CFG_EYE       = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_SAT      = 2'd2
    } t_status;

endpackage

### rtl/ppp_point_if.sv
interface ppp_point_if #(parameter int COORD_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

### rtl/ppp_screen_if.sv
interface ppp_screen_if #(parameter int COORD_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] screen_x;
    logic signed [COORD_WIDTH-1:0] screen_y;
    logic [1:0]                    status;

    modport source (output valid, screen_x, screen_y, status, input ready);
    modport sink   (input valid, screen_x, screen_y, status, output ready);
endinterface

### rtl/ppp_front.sv
module ppp_front import ppp_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ppp_point_if.sink                   i_point,
    input  logic [3*COEF_WIDTH-1:0]     i_row_x,
    input  logic [3*COEF_WIDTH-1:0]     i_row_y,
    input  logic [3*COEF_WIDTH-1:0]     i_row_z,
    input  logic [EYE_W-1:0]            i_eye,
    input  logic                        i_full,
    output logic                        o_valid,
    output logic [COORD_WIDTH+COEF_WIDTH+1:0] o_dx,
    output logic [COORD_WIDTH+COEF_WIDTH+1:0] o_dy,
    output logic [((COORD_WIDTH+COEF_WIDTH+2 > EYE_W+COEF_WIDTH-1) ?
                   COORD_WIDTH+COEF_WIDTH+2 : EYE_W+COEF_WIDTH-1):0] o_den
);
    localparam int W    = COORD_WIDTH;
    localparam int C    = COEF_WIDTH;
    localparam int F    = C - 2;
    localparam int PW   = W + C;
    localparam int DW   = W + C + 2;
    localparam int DENW = ((DW > EYE_W + F + 1) ? DW : EYE_W + F + 1) + 1;

    logic signed [C-1:0]  coef [3][3];
    logic signed [W-1:0]  pt   [3];
    logic signed [PW-1:0] r_prod [3][3];
    logic signed [DW-1:0] r_dx, r_dy, n_dx, n_dy, n_dz;
    logic signed [DENW-1:0] r_den, n_den;
    logic r_v1, r_v2, rdy1, rdy2;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            coef[0][k] = i_row_x[k*C +: C];
            coef[1][k] = i_row_y[k*C +: C];
            coef[2][k] = i_row_z[k*C +: C];
        end
        pt[0] = i_point.point_x;
        pt[1] = i_point.point_y;
        pt[2] = i_point.point_z;
    end

    // advance a stage when the one below is free or moving
    assign rdy2          = !r_v2 || !i_full;
    assign rdy1          = !r_v1 || rdy2;
    assign i_point.ready = rdy1;

    always_comb begin
        n_dx  = DW'(r_prod[0][0]) + DW'(r_prod[0][1]) + DW'(r_prod[0][2]);
        n_dy  = DW'(r_prod[1][0]) + DW'(r_prod[1][1]) + DW'(r_prod[1][2]);
        n_dz  = DW'(r_prod[2][0]) + DW'(r_prod[2][1]) + DW'(r_prod[2][2]);
        n_den = DENW'({i_eye, {F{1'b0}}}) + DENW'(n_dz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_point.valid;
            if (rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_point.valid) begin
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 3; k++)
                    r_prod[r][k] <= PW'(pt[k]) * PW'(coef[r][k]);
        end
        if (rdy2 && r_v1) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_den <= n_den;
        end
    end

    assign o_valid = r_v2;
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;
    assign o_den   = r_den;
endmodule

### rtl/ppp_queue.sv
`include "perspective_point_projector_macros.svh"
module ppp_queue import ppp_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    output logic             o_pop_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data
);
    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             push;

    assign o_full      = (r_count == CW'(DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign push        = i_push_valid && !o_full;
    assign o_pop_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push)  r_wr <= r_wr + 1'b1;
            if (i_pop) r_rd <= r_rd + 1'b1;
            if (push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_push_data;
    end

    `PPP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "queue overfilled")
    `PPP_ASSERT(a_pop_nonempty, i_clk, i_rst_n, !i_pop || (r_count != '0), "pop from empty queue")
    `PPP_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, push && !i_pop, r_count == $past(r_count) + 1'b1, "queue count lost a beat")
endmodule

### rtl/ppp_back.sv
`include "perspective_point_projector_macros.svh"
module ppp_back import ppp_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [COORD_WIDTH+COEF_WIDTH+1:0] i_dx,
    input  logic [COORD_WIDTH+COEF_WIDTH+1:0] i_dy,
    input  logic [((COORD_WIDTH+COEF_WIDTH+2 > EYE_W+COEF_WIDTH-1) ?
                   COORD_WIDTH+COEF_WIDTH+2 : EYE_W+COEF_WIDTH-1):0] i_den,
    input  logic [EYE_W-1:0]      i_eye,
    output logic                  o_pop,
    ppp_screen_if.source          o_screen
);
    localparam int W    = COORD_WIDTH;
    localparam int C    = COEF_WIDTH;
    localparam int F    = C - 2;
    localparam int DW   = W + C + 2;
    localparam int DENW = ((DW > EYE_W + F + 1) ? DW : EYE_W + F + 1) + 1;
    localparam int HW   = (DW + 1) / 2;
    localparam int NUMW = DW + EYE_W;
    localparam int RW   = (NUMW > DENW + W) ? NUMW : DENW + W;

    logic en;

    logic r_v1, r_v2, r_v3, r_out_v;
    logic [DW-1:0]   r1_xm, r1_ym;
    logic [DENW-1:0] r1_dm, r2_dm, r3_dm;
    logic r1_xn, r1_yn, r1_zr, r2_xn, r2_yn, r2_zr, r3_xn, r3_yn, r3_zr;
    logic [HW+EYE_W-1:0]    r2_xlo, r2_ylo;
    logic [DW-HW+EYE_W-1:0] r2_xhi, r2_yhi;
    logic [NUMW-1:0] r3_xnum, r3_ynum;

    logic            r_vd  [W+1];
    logic [RW-1:0]   r_rx  [W+1];
    logic [RW-1:0]   r_ry  [W+1];
    logic [W-1:0]    r_qx  [W+1];
    logic [W-1:0]    r_qy  [W+1];
    logic [DENW-1:0] r_dd  [W+1];
    logic            r_xn  [W+1];
    logic            r_yn  [W+1];
    logic            r_zr  [W+1];
    logic            r_ovx [W+1];
    logic            r_ovy [W+1];

    logic signed [W-1:0] r_sx, r_sy;
    t_status             r_status;

    logic signed [DW-1:0]   dx, dy;
    logic signed [DENW-1:0] den;
    logic [RW-1:0]          den_top;
    logic [W-1:0]           sx, sy;
    logic                   satx, saty;

    // hold the whole pipeline while a finished beat waits
    assign en    = !r_out_v || o_screen.ready;
    assign o_pop = en && i_valid;

    assign dx      = i_dx;
    assign dy      = i_dy;
    assign den     = i_den;
    assign den_top = RW'(r3_dm) << W;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_out_v <= 1'b0;
            for (int j = 0; j <= W; j++) r_vd[j] <= 1'b0;
        end else if (en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_vd[0] <= r_v3;
            for (int j = 1; j <= W; j++) r_vd[j] <= r_vd[j-1];
            r_out_v <= r_vd[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_xm <= dx[DW-1] ? DW'(-dx) : DW'(dx);
            r1_ym <= dy[DW-1] ? DW'(-dy) : DW'(dy);
            r1_dm <= den[DENW-1] ? DENW'(-den) : DENW'(den);
            r1_xn <= dx[DW-1] ^ den[DENW-1];
            r1_yn <= dy[DW-1] ^ den[DENW-1];
            r1_zr <= (den == '0);

            r2_xlo <= (HW+EYE_W)'(r1_xm[HW-1:0]) * (HW+EYE_W)'(i_eye);
            r2_xhi <= (DW-HW+EYE_W)'(r1_xm[DW-1:HW]) * (DW-HW+EYE_W)'(i_eye);
            r2_ylo <= (HW+EYE_W)'(r1_ym[HW-1:0]) * (HW+EYE_W)'(i_eye);
            r2_yhi <= (DW-HW+EYE_W)'(r1_ym[DW-1:HW]) * (DW-HW+EYE_W)'(i_eye);
            r2_dm  <= r1_dm;
            r2_xn  <= r1_xn;
            r2_yn  <= r1_yn;
            r2_zr  <= r1_zr;

            r3_xnum <= (NUMW'(r2_xhi) << HW) + NUMW'(r2_xlo);
            r3_ynum <= (NUMW'(r2_yhi) << HW) + NUMW'(r2_ylo);
            r3_dm   <= r2_dm;
            r3_xn   <= r2_xn;
            r3_yn   <= r2_yn;
            r3_zr   <= r2_zr;

            // a quotient of 2^W or more saturates either way
            r_rx[0]  <= RW'(r3_xnum);
            r_ry[0]  <= RW'(r3_ynum);
            r_ovx[0] <= RW'(r3_xnum) >= den_top;
            r_ovy[0] <= RW'(r3_ynum) >= den_top;
            r_qx[0]  <= '0;
            r_qy[0]  <= '0;
            r_dd[0]  <= r3_dm;
            r_xn[0]  <= r3_xn;
            r_yn[0]  <= r3_yn;
            r_zr[0]  <= r3_zr;
        end
    end

    for (genvar j = 1; j <= W; j++) begin : g_div
        logic [RW-1:0] dsh;
        logic          gex, gey;

        assign dsh = RW'(r_dd[j-1]) << (W - j);
        assign gex = r_rx[j-1] >= dsh;
        assign gey = r_ry[j-1] >= dsh;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rx[j]  <= gex ? r_rx[j-1] - dsh : r_rx[j-1];
                r_ry[j]  <= gey ? r_ry[j-1] - dsh : r_ry[j-1];
                r_qx[j]  <= r_qx[j-1] | (W'(gex) << (W - j));
                r_qy[j]  <= r_qy[j-1] | (W'(gey) << (W - j));
                r_ovx[j] <= r_ovx[j-1];
                r_ovy[j] <= r_ovy[j-1];
                r_dd[j]  <= r_dd[j-1];
                r_xn[j]  <= r_xn[j-1];
                r_yn[j]  <= r_yn[j-1];
                r_zr[j]  <= r_zr[j-1];
            end
        end
    end

    function automatic logic [W:0] clamp(input logic [W-1:0] q, input logic ov,
                                         input logic neg);
        logic [W-1:0] half;
        logic         big;
        half = W'(1) << (W - 1);
        if (neg) begin
            big = ov || (q[W-1] && (q[W-2:0] != '0));
            return big ? {1'b1, half} : {1'b0, W'(-q)};
        end
        big = ov || q[W-1];
        return big ? {1'b1, half - 1'b1} : {1'b0, q};
    endfunction

    always_comb begin
        {satx, sx} = clamp(r_qx[W], r_ovx[W], r_xn[W]);
        {saty, sy} = clamp(r_qy[W], r_ovy[W], r_yn[W]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_zr[W]) begin
                r_sx     <= '0;
                r_sy     <= '0;
                r_status <= ST_ZERO_DEN;
            end else begin
                r_sx     <= sx;
                r_sy     <= sy;
                r_status <= (satx || saty) ? ST_SAT : ST_OK;
            end
        end
    end

    assign o_screen.valid    = r_out_v;
    assign o_screen.screen_x = r_sx;
    assign o_screen.screen_y = r_sy;
    assign o_screen.status   = r_status;

    `PPP_ASSERT(a_zero_den_out, i_clk, i_rst_n, !(r_out_v && r_status == ST_ZERO_DEN) || (r_sx == '0 && r_sy == '0), "zero denominator beat carries a value")
    `PPP_ASSERT(a_sat_bound, i_clk, i_rst_n, !(r_out_v && r_status == ST_SAT) || (r_sx[W-2:0] == '0 && r_sx[W-1]) || (r_sx[W-2:0] == '1 && !r_sx[W-1]) || (r_sy[W-2:0] == '0 && r_sy[W-1]) || (r_sy[W-2:0] == '1 && !r_sy[W-1]), "saturated beat not at a bound")
endmodule

### rtl/perspective_point_projector.sv
// Perspective point projector.
// i_point carries one 3D point (Q16.16 x, y, z) per beat; o_screen returns one
// beat per point with the rotated, projected x and y and a status code
// (ok, zero denominator, saturated). Both channels move a beat when valid and
// ready are high at a rising edge.
// Rows of the rotation matrix and the eye distance are written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while
// no point is in flight; the block does not enforce it. Throughput: one point
// per cycle while o_screen.ready is high. The front registers products, then
// sums; the queue follows, then the restoring divider, one quotient bit a stage.
// A four-entry queue sits between front and back; when the receiver holds
// o_screen.ready low the back stalls as a whole, the front keeps filling the
// queue and i_point.ready drops once it and the front stages are full.
// Reset (synchronous, active low) empties the pipeline and queue and loads
// the identity matrix and an eye distance of 10.0.
module perspective_point_projector import ppp_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    ppp_point_if.sink               i_point,
    ppp_screen_if.source            o_screen,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [3*COEF_WIDTH-1:0] i_cfg_data
);
    localparam int C    = COEF_WIDTH;
    localparam int F    = C - 2;
    localparam int RWD  = 3 * C;
    localparam int DW   = COORD_WIDTH + C + 2;
    localparam int DENW = ((DW > EYE_W + F + 1) ? DW : EYE_W + F + 1) + 1;
    localparam int QW   = 2 * DW + DENW;
    localparam logic [RWD-1:0] ONE = RWD'(1) << F;

    logic [RWD-1:0]   r_row_x, r_row_y, r_row_z;
    logic [EYE_W-1:0] r_eye;

    logic            f_valid, q_full, q_valid, q_pop;
    logic [DW-1:0]   f_dx, f_dy;
    logic [DENW-1:0] f_den;
    logic [QW-1:0]   q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x <= ONE;
            r_row_y <= ONE << C;
            r_row_z <= ONE << (2 * C);
            r_eye   <= EYE_W'(655360);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_ROW_X:     r_row_x <= i_cfg_data;
                CFG_ROW_Y:     r_row_y <= i_cfg_data;
                CFG_ROW_DEPTH: r_row_z <= i_cfg_data;
                CFG_EYE:       r_eye   <= i_cfg_data[EYE_W-1:0];
            endcase
        end
    end

    ppp_front #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (i_point),
        .i_row_x (r_row_x),
        .i_row_y (r_row_y),
        .i_row_z (r_row_z),
        .i_eye   (r_eye),
        .i_full  (q_full),
        .o_valid (f_valid),
        .o_dx    (f_dx),
        .o_dy    (f_dy),
        .o_den   (f_den)
    );

    ppp_queue #(.WIDTH(QW)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .i_push_data  ({f_dx, f_dy, f_den}),
        .o_full       (q_full),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_data   (q_data)
    );

    ppp_back #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_dx     (q_data[QW-1 -: DW]),
        .i_dy     (q_data[DW+DENW-1 -: DW]),
        .i_den    (q_data[DENW-1:0]),
        .i_eye    (r_eye),
        .o_pop    (q_pop),
        .o_screen (o_screen)
    );
endmodule
